// File: design/dafe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dafe_pkg: shared definitions for the delta and acceleration feature block
// Widths, limits, register indexes, command and status structures.
// ----------------------------------------------------------------------------
package dafe_pkg;

	localparam int SAMPLE_W     = 24;
	localparam int DELTA_W      = SAMPLE_W + 1;
	localparam int ACC_W        = SAMPLE_W + 2;
	localparam int VAL_W        = SAMPLE_W + 2;
	localparam int IDX_W        = 6;
	localparam int MAX_FEATURES = 64;
	localparam int MAX_WINDOW   = 4;
	localparam int WIN_W        = 3;
	localparam int NF_W         = 7;
	localparam int RING_FRAMES  = 4 * MAX_WINDOW + 1;
	localparam int RING_W       = 5;
	localparam int ADDR_W       = RING_W + IDX_W;
	localparam int MEM_DEPTH    = RING_FRAMES * MAX_FEATURES;
	localparam int FRAME_W      = 32;
	localparam int OFF_W        = 6;
	localparam int SUM_W        = 32;
	localparam int DEN_W        = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;

	// Reciprocal division: numerators below 2^RECIP_N_W, reciprocals scaled
	// by 2^RECIP_SHIFT and rounded up.
	localparam int RECIP_N_W   = 28;
	localparam int RECIP_M_W   = 30;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_M_W-1:0] RECIP_5  = 30'h3333_3334;
	localparam logic [RECIP_M_W-1:0] RECIP_7  = 30'h2492_4925;
	localparam logic [RECIP_M_W-1:0] RECIP_15 = 30'h1111_1112;

	localparam logic [CFG_IDX_W-1:0] REG_DELTA_WIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACC_WIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FEAT  = 2'd2;

	typedef enum logic [1:0] {
		TK_DELTA  = 2'd0,
		TK_DPLUS  = 2'd1,
		TK_DMINUS = 2'd2,
		TK_ACC    = 2'd3
	} take_t;

	typedef struct packed {
		logic             ready;
		logic             accept;
		logic             rd_en;
		logic [WIN_W-1:0] tap_d;
		logic             tap_neg;
		logic             cen_acc;
		logic [WIN_W-1:0] cen_a;
		logic             cen_neg;
		logic             cap_static;
		logic             cap_p;
		logic             clr_dsum;
		logic             dsum_add;
		logic             clr_asum;
		logic             div_start;
		logic             div_acc;
		logic             take;
		take_t            take_sel;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic             job;
		logic [WIN_W-1:0] w_eff;
		logic [WIN_W-1:0] a_eff;
		logic             div_done;
		logic             out_full;
	} status_t;

	// Normalizer of a regression window of half width w.
	function automatic logic [DEN_W-1:0] win_den(input logic [WIN_W-1:0] w);
		logic [DEN_W-1:0] r;
		case (w)
			3'd1: r = 7'd2;
			3'd2: r = 7'd10;
			3'd3: r = 7'd28;
			3'd4: r = 7'd60;
			default: r = 7'd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [OFF_W-1:0] off_clamp(input logic signed [OFF_W-1:0] x,
			input logic signed [OFF_W-1:0] lo);
		logic signed [OFF_W-1:0] r;
		if (x > 0)
			r = '0;
		else if (x < lo)
			r = lo;
		else
			r = x;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/dafe_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dafe_in_if: input item channel
// Valid/ready channel carrying one coefficient or drain command.
// ----------------------------------------------------------------------------
interface dafe_in_if;
	import dafe_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       last_frame;
	modport source(output valid, command, sample_value, last_frame, input ready);
	modport sink(input valid, command, sample_value, last_frame, output ready);
endinterface
`default_nettype wire

// File: design/dafe_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dafe_out_if: result item channel
// Valid/ready channel carrying one static, delta and acceleration element.
// ----------------------------------------------------------------------------
interface dafe_out_if;
	import dafe_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] static_value;
	logic signed [DELTA_W-1:0]  delta_value;
	logic signed [ACC_W-1:0]    acc_value;
	logic [IDX_W-1:0]           feature_index;
	logic                       utterance_end;
	modport source(output valid, static_value, delta_value, acc_value, feature_index,
		utterance_end, input ready);
	modport sink(input valid, static_value, delta_value, acc_value, feature_index,
		utterance_end, output ready);
endinterface
`default_nettype wire

// File: design/dafe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dafe_div: divider by twice a window normalizer
// Shift and reciprocal multiplication, sign applied at the end.
// ----------------------------------------------------------------------------
module dafe_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [dafe_pkg::SUM_W-1:0]        num,
	input  logic [dafe_pkg::DEN_W-1:0]        den,
	input  logic                              neg,
	output logic                              busy,
	output logic                              done,
	output logic signed [dafe_pkg::SUM_W-1:0] quo
);
	import dafe_pkg::*;

	logic                             v_s1;
	logic                             done_q;
	logic [RECIP_N_W-1:0]             n_s1;
	logic [RECIP_M_W-1:0]             m_s1;
	logic                             byp_s1;
	logic                             neg_s1;
	logic [RECIP_N_W-1:0]             n_c;
	logic [RECIP_M_W-1:0]             m_c;
	logic                             byp_c;
	logic [RECIP_N_W+RECIP_M_W-1:0]   prod;
	logic [RECIP_N_W-1:0]             q_c;
	logic signed [SUM_W-1:0]          quo_q;

	// The divisor is 4, 20, 56 or 120: a power of two times 1, 5, 7 or 15.
	// The power of two is a shift; the odd factor is a multiply by its
	// reciprocal, exact for every shifted numerator below 2^28.
	always_comb begin
		case (den)
			7'd4: begin
				n_c   = RECIP_N_W'(num >> 2);
				m_c   = '0;
				byp_c = 1'b1;
			end
			7'd20: begin
				n_c   = RECIP_N_W'(num >> 2);
				m_c   = RECIP_5;
				byp_c = 1'b0;
			end
			7'd56: begin
				n_c   = RECIP_N_W'(num >> 3);
				m_c   = RECIP_7;
				byp_c = 1'b0;
			end
			7'd120: begin
				n_c   = RECIP_N_W'(num >> 3);
				m_c   = RECIP_15;
				byp_c = 1'b0;
			end
			default: begin
				n_c   = RECIP_N_W'(num >> 1);
				m_c   = '0;
				byp_c = 1'b1;
			end
		endcase
	end

	assign prod = n_s1 * m_s1;
	assign q_c  = byp_s1 ? n_s1 : RECIP_N_W'(prod >> RECIP_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_s1   <= n_c;
			m_s1   <= m_c;
			byp_s1 <= byp_c;
			neg_s1 <= neg;
		end
		if (v_s1)
			quo_q <= neg_s1 ? -$signed(SUM_W'(q_c)) : $signed(SUM_W'(q_c));
	end

	assign busy = v_s1;
	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// File: design/dafe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dafe_datapath: history ring, frame tracking and window arithmetic
// Holds the configuration, the utterance counters, the static ring memory,
// the tap accumulators, the shared divider and the result register.
// ----------------------------------------------------------------------------
module dafe_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [dafe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dafe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_command,
	input  logic signed [dafe_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                 in_last,
	input  dafe_pkg::cmd_t                       cmd,
	output dafe_pkg::status_t                    status,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic signed [dafe_pkg::SAMPLE_W-1:0] res_static,
	output logic signed [dafe_pkg::DELTA_W-1:0]  res_delta,
	output logic signed [dafe_pkg::ACC_W-1:0]    res_acc,
	output logic [dafe_pkg::IDX_W-1:0]           res_index,
	output logic                                 res_end
);
	import dafe_pkg::*;

	// Configuration.
	logic [WIN_W-1:0] dw_q, aw_q;
	logic [NF_W-1:0]  nf_q;
	logic [WIN_W-1:0] w_eff, a_eff;
	logic [NF_W-1:0]  nf_eff, nf_m1;
	logic [3:0]       lag;
	logic [FRAME_W-1:0] lag32;

	// Utterance tracking.
	logic [FRAME_W-1:0] fc_q, emit_q, fc_e, emit_e, hi_sel;
	logic [RING_W-1:0]  fm_q, fm_e;
	logic [IDX_W-1:0]   cpos_q, cp_e, pos_c;
	logic               closed_q, reopen, frame_end, coef_emit, drain_ok;

	// Job latched at acceptance.
	logic                    job_q, end_q;
	logic signed [OFF_W-1:0] o_q, lo_q;
	logic [RING_W-1:0]       hm_q;
	logic [IDX_W-1:0]        pos_q;
	logic signed [OFF_W-1:0] o_c, lo_c;

	// Memory and arithmetic.
	logic signed [SAMPLE_W-1:0] mem [0:MEM_DEPTH-1];
	logic signed [SAMPLE_W-1:0] rdata_q, static_q, p_q;
	logic signed [SUM_W-1:0]    dsum_q, asum_q;
	logic signed [VAL_W-1:0]    dp_q, delta_q, acc_q;
	logic signed [OFF_W-1:0]    cen, tap;
	logic signed [OFF_W:0]      t_raw;
	logic [RING_W-1:0]          ring;
	logic [ADDR_W-1:0]          raddr;
	logic signed [SUM_W-1:0]    div_sum, mag, tap_diff, acc_diff;
	logic [WIN_W-1:0]           div_w;
	logic [DEN_W-1:0]           div_den;
	logic [SUM_W-1:0]           div_num;
	logic                       div_busy, div_done;
	logic signed [SUM_W-1:0]    quo;
	logic signed [VAL_W-1:0]    qv;
	logic                       out_full_q;

	assign w_eff  = (dw_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : dw_q;
	assign a_eff  = (dw_q == '0) ? '0 : ((aw_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : aw_q);
	assign nf_eff = (nf_q == '0) ? NF_W'(1) :
		((nf_q > NF_W'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES) : nf_q);
	assign nf_m1  = nf_eff - 1'b1;
	assign lag    = {1'b0, w_eff} + {1'b0, a_eff};
	assign lag32  = FRAME_W'(lag);

	assign reopen = closed_q && !in_command;
	assign fc_e   = reopen ? '0 : fc_q;
	assign fm_e   = reopen ? '0 : fm_q;
	assign cp_e   = reopen ? '0 : cpos_q;
	assign emit_e = reopen ? '0 : emit_q;
	assign pos_c  = ({1'b0, cp_e} >= nf_eff) ? nf_m1[IDX_W-1:0] : cp_e;
	assign frame_end = pos_c == nf_m1[IDX_W-1:0];
	assign coef_emit = fc_e >= lag32;
	assign drain_ok  = closed_q && !(emit_q > fc_q);
	assign hi_sel    = in_command ? fc_q : fc_e;
	assign lo_c      = (hi_sel >= FRAME_W'(RING_FRAMES - 1)) ? -OFF_W'(RING_FRAMES - 1) :
		-$signed({1'b0, hi_sel[RING_W-1:0]});
	assign o_c       = in_command ? $signed(OFF_W'(emit_q - fc_q)) : -$signed(OFF_W'(lag));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q     <= WIN_W'(2);
			aw_q     <= WIN_W'(2);
			nf_q     <= NF_W'(13);
			fc_q     <= '0;
			fm_q     <= '0;
			cpos_q   <= '0;
			emit_q   <= '0;
			closed_q <= 1'b0;
			job_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_DELTA_WIN: dw_q <= cfg_data[WIN_W-1:0];
					REG_ACC_WIN:   aw_q <= cfg_data[WIN_W-1:0];
					REG_NUM_FEAT:  nf_q <= cfg_data[NF_W-1:0];
					default: ;
				endcase
			end
			job_q <= cmd.accept && (in_command ? drain_ok : coef_emit);
			if (cmd.accept && !in_command) begin
				emit_q <= emit_e;
				fc_q   <= fc_e;
				fm_q   <= fm_e;
				closed_q <= 1'b0;
				if (frame_end && in_last) begin
					closed_q <= 1'b1;
					cpos_q   <= '0;
					emit_q   <= coef_emit ? fc_e - lag32 + 1'b1 : '0;
				end else if (frame_end) begin
					cpos_q <= '0;
					fc_q   <= fc_e + 1'b1;
					fm_q   <= (fm_e == RING_W'(RING_FRAMES - 1)) ? '0 : fm_e + 1'b1;
				end else begin
					cpos_q <= pos_c + 1'b1;
				end
			end else if (cmd.accept && drain_ok) begin
				if (frame_end) begin
					cpos_q <= '0;
					emit_q <= emit_q + 1'b1;
				end else begin
					cpos_q <= pos_c + 1'b1;
				end
			end
		end
	end

	// Tap address: center frame, then tap frame, both clamped to the utterance.
	assign cen   = cmd.cen_acc ? off_clamp(cmd.cen_neg ? o_q - $signed({3'b0, cmd.cen_a}) :
		o_q + $signed({3'b0, cmd.cen_a}), lo_q) : o_q;
	assign tap   = off_clamp(cmd.tap_neg ? cen - $signed({3'b0, cmd.tap_d}) :
		cen + $signed({3'b0, cmd.tap_d}), lo_q);
	assign t_raw = $signed({2'b0, hm_q}) + (OFF_W + 1)'(RING_FRAMES) + (OFF_W + 1)'(tap);
	assign ring  = (t_raw >= (OFF_W + 1)'(RING_FRAMES)) ?
		RING_W'(t_raw - (OFF_W + 1)'(RING_FRAMES)) : t_raw[RING_W-1:0];
	assign raddr = {ring, pos_q};

	always_ff @(posedge clk) begin
		if (cmd.accept && !in_command)
			mem[{fm_e, pos_c}] <= in_sample;
		if (cmd.rd_en)
			rdata_q <= mem[raddr];
	end

	assign tap_diff = SUM_W'(p_q) - SUM_W'(rdata_q);
	assign qv       = quo[VAL_W-1:0];
	assign acc_diff = SUM_W'(dp_q) - SUM_W'(qv);
	assign div_sum  = cmd.div_acc ? asum_q : dsum_q;
	assign div_w    = cmd.div_acc ? a_eff : w_eff;
	assign div_den  = win_den(div_w);
	assign mag      = (div_sum < 0) ? -div_sum : div_sum;
	assign div_num  = {mag[SUM_W-2:0], 1'b0} + SUM_W'(div_den);

	dafe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    ({div_den[DEN_W-2:0], 1'b0}),
		.neg    (div_sum < 0),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			o_q     <= o_c;
			lo_q    <= lo_c;
			hm_q    <= in_command ? fm_q : fm_e;
			pos_q   <= pos_c;
			end_q   <= in_command ? ((emit_q == fc_q) && frame_end) :
				(frame_end && in_last && (lag == '0));
			delta_q <= '0;
			acc_q   <= '0;
		end
		if (cmd.cap_static)
			static_q <= rdata_q;
		if (cmd.cap_p)
			p_q <= rdata_q;
		if (cmd.clr_dsum)
			dsum_q <= '0;
		else if (cmd.dsum_add)
			dsum_q <= dsum_q + tap_diff * $signed({29'd0, cmd.tap_d});
		if (cmd.clr_asum)
			asum_q <= '0;
		if (cmd.take) begin
			case (cmd.take_sel)
				TK_DELTA:  delta_q <= qv;
				TK_DPLUS:  dp_q    <= qv;
				TK_DMINUS: asum_q  <= asum_q + acc_diff * $signed({29'd0, cmd.cen_a});
				TK_ACC:    acc_q   <= qv;
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			res_static <= static_q;
			res_delta  <= delta_q[DELTA_W-1:0];
			res_acc    <= acc_q[ACC_W-1:0];
			res_index  <= pos_q;
			res_end    <= end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_full_q <= 1'b0;
		else if (cmd.load_out)
			out_full_q <= 1'b1;
		else if (res_ready)
			out_full_q <= 1'b0;
	end

	assign res_valid       = out_full_q;
	assign status.job      = job_q;
	assign status.w_eff    = w_eff;
	assign status.a_eff    = a_eff;
	assign status.div_done = div_done;
	assign status.out_full = out_full_q;

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_full_q) else $error("result register overwritten");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy) else $error("divider restarted while busy");
	a_job_origin: assert property (@(posedge clk) disable iff (!arst_n)
		job_q |-> $past(cmd.accept)) else $error("job without an accepted item");
	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		fm_q < RING_W'(RING_FRAMES)) else $error("ring slot out of range");
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !div_busy && !cmd.rd_en) else $error("item taken while busy");
endmodule
`default_nettype wire

// File: design/dafe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dafe_ctrl: sequencer for one element
// Walks the static read, the delta taps, the acceleration taps and the
// divisions, then hands the element to the result register.
// ----------------------------------------------------------------------------
module dafe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  dafe_pkg::status_t status,
	output dafe_pkg::cmd_t    cmd
);
	import dafe_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_DECIDE  = 10'b0000000010,
		S_ST_RD   = 10'b0000000100,
		S_ST_CAP  = 10'b0000001000,
		S_TAP_P   = 10'b0000010000,
		S_TAP_M   = 10'b0000100000,
		S_TAP_ACC = 10'b0001000000,
		S_DIV_ST  = 10'b0010000000,
		S_DIV_RUN = 10'b0100000000,
		S_OUT     = 10'b1000000000
	} state_t;

	state_t           state_q, state_d;
	logic [WIN_W-1:0] d_q, d_d, a_q, a_d;
	logic             mode_q, mode_d, side_q, side_d, fin_q, fin_d;

	always_comb begin
		cmd      = '0;
		cmd.take_sel = TK_DELTA;
		state_d  = state_q;
		d_d      = d_q;
		a_d      = a_q;
		mode_d   = mode_q;
		side_d   = side_q;
		fin_d    = fin_q;
		cmd.cen_acc = mode_q;
		cmd.cen_a   = a_q;
		cmd.cen_neg = side_q;
		cmd.tap_d   = d_q;
		case (state_q)
			S_IDLE: begin
				cmd.ready  = 1'b1;
				cmd.accept = in_valid;
				if (in_valid)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = status.job ? S_ST_RD : S_IDLE;
			end
			S_ST_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.cen_acc = 1'b0;
				cmd.tap_d   = '0;
				state_d     = S_ST_CAP;
			end
			S_ST_CAP: begin
				cmd.cap_static = 1'b1;
				cmd.clr_dsum   = 1'b1;
				mode_d = 1'b0;
				fin_d  = 1'b0;
				d_d    = WIN_W'(1);
				state_d = (status.w_eff == '0) ? S_OUT : S_TAP_P;
			end
			S_TAP_P: begin
				cmd.rd_en = 1'b1;
				state_d   = S_TAP_M;
			end
			S_TAP_M: begin
				cmd.cap_p   = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.tap_neg = 1'b1;
				state_d     = S_TAP_ACC;
			end
			S_TAP_ACC: begin
				cmd.dsum_add = 1'b1;
				if (d_q == status.w_eff) begin
					state_d = S_DIV_ST;
				end else begin
					d_d     = d_q + 1'b1;
					state_d = S_TAP_P;
				end
			end
			S_DIV_ST: begin
				cmd.div_start = 1'b1;
				cmd.div_acc   = fin_q;
				state_d       = S_DIV_RUN;
			end
			S_DIV_RUN: begin
				if (status.div_done) begin
					cmd.take = 1'b1;
					d_d      = WIN_W'(1);
					if (fin_q) begin
						cmd.take_sel = TK_ACC;
						state_d      = S_OUT;
					end else if (!mode_q) begin
						cmd.take_sel = TK_DELTA;
						if (status.a_eff == '0) begin
							state_d = S_OUT;
						end else begin
							cmd.clr_asum = 1'b1;
							cmd.clr_dsum = 1'b1;
							mode_d  = 1'b1;
							a_d     = WIN_W'(1);
							side_d  = 1'b0;
							state_d = S_TAP_P;
						end
					end else if (!side_q) begin
						cmd.take_sel = TK_DPLUS;
						cmd.clr_dsum = 1'b1;
						side_d  = 1'b1;
						state_d = S_TAP_P;
					end else begin
						cmd.take_sel = TK_DMINUS;
						if (a_q == status.a_eff) begin
							fin_d   = 1'b1;
							state_d = S_DIV_ST;
						end else begin
							cmd.clr_dsum = 1'b1;
							a_d     = a_q + 1'b1;
							side_d  = 1'b0;
							state_d = S_TAP_P;
						end
					end
				end
			end
			S_OUT: begin
				if (!status.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			d_q     <= '0;
			a_q     <= '0;
			mode_q  <= 1'b0;
			side_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			d_q     <= d_d;
			a_q     <= a_d;
			mode_q  <= mode_d;
			side_q  <= side_d;
			fin_q   <= fin_d;
		end
	end
endmodule
`default_nettype wire

// File: design/delta_acceleration_features_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_acceleration_features_core: streaming regression delta features
// Static, delta and acceleration coefficients for each input coefficient.
// ----------------------------------------------------------------------------
// Coefficients arrive one per transfer, num_features per frame. Each element
// comes out lag = delta_window + acc_window frames later (lag is zero when
// delta_window is zero), and after the frame flagged last_frame one drain
// transfer flushes one pending element. The block handles one item at a time.
// An element skips the taps and divisions when the delta half width W is zero
// and the acceleration taps when the acceleration half width A is zero, and
// it waits for the result register to empty before it is loaded there. Its
// time is set by the single read port of the history ring, which reads the
// taps one after another, and the shared divider, which does each rounding
// division by shift and reciprocal multiply. The result sits in an output
// register, so the next item is taken while a finished element waits.
// History is a ring of 17 frames of 64 coefficients with no clearing pass.
module delta_acceleration_features_core (
	input  logic                              clk,
	input  logic                              arst_n,
	dafe_in_if.sink                           item,
	dafe_out_if.source                        result,
	input  logic                              cfg_wen,
	input  logic [dafe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dafe_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dafe_pkg::*;

	cmd_t    cmd;
	status_t status;

	// The sequencer issues commands; the datapath answers with status only.
	dafe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.status   (status),
		.cmd      (cmd)
	);

	assign item.ready = cmd.ready;

	dafe_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_command (item.command),
		.in_sample  (item.sample_value),
		.in_last    (item.last_frame),
		.cmd        (cmd),
		.status     (status),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_static (result.static_value),
		.res_delta  (result.delta_value),
		.res_acc    (result.acc_value),
		.res_index  (result.feature_index),
		.res_end    (result.utterance_end)
	);
endmodule
`default_nettype wire
